// File: hw/rtl/tir_pkg.sv
// shared types and constants for the timestamped interpolation ring
// no dependencies; imported by every module of the block
package tir_pkg;

  localparam int RING_DEPTH_DEF = 16;

  localparam int TIME_W    = 48;
  localparam int PAYLOAD_W = 64;
  localparam int ALPHA_W   = 17;
  localparam int HELD_W    = 5;
  localparam int REM_W     = TIME_W + 1;

  // one quotient bit per step: integer bit plus 16 fraction bits
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(ALPHA_W);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_CHECK,
    S_DIV,
    S_EMIT
  } tir_state_t;

  typedef struct packed {
    logic capture;
    logic do_write;
    logic rd_issue;
    logic drop;
    logic take_pair;
    logic div_start;
    logic div_step;
    logic load_out;
  } tir_cmd_t;

  typedef struct packed {
    logic few;
    logic stale;
    logic bracket;
    logic span;
    logic div_last;
  } tir_sts_t;

endpackage

// File: hw/rtl/tir_ctrl.sv
// controller state machine of the interpolation ring
// depends on tir_pkg; drives the datapath tir_dp through tir_cmd_t
module tir_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tir_pkg::tir_sts_t  sts,
  output tir_pkg::tir_cmd_t  cmd
);
  import tir_pkg::*;

  tir_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_op == OP_QUERY) ? S_READ : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.do_write = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_READ: begin
        if (sts.few) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.stale) begin
          // second oldest already behind the query time
          cmd.drop  = 1'b1;
          state_nxt = S_READ;
        end else if (sts.bracket) begin
          cmd.take_pair = 1'b1;
          cmd.drop      = 1'b1;
          if (sts.span) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_EMIT;
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/tir_dp.sv
// datapath of the interpolation ring: snapshot memories, ring pointers,
// serial alpha divider and output register; depends on tir_pkg
module tir_dp #(
  parameter int RING_DEPTH = tir_pkg::RING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_op,
  input  logic [tir_pkg::TIME_W-1:0]       in_item_time,
  input  logic [tir_pkg::PAYLOAD_W-1:0]    in_item_payload,
  input  tir_pkg::tir_cmd_t                cmd,
  output tir_pkg::tir_sts_t                sts,
  output logic                             out_was_query,
  output logic                             out_found,
  output logic [tir_pkg::PAYLOAD_W-1:0]    out_earlier_payload,
  output logic [tir_pkg::PAYLOAD_W-1:0]    out_later_payload,
  output logic [tir_pkg::ALPHA_W-1:0]      out_alpha,
  output logic [tir_pkg::HELD_W-1:0]       out_entries_held
);
  import tir_pkg::*;

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // snapshot store
  logic [TIME_W-1:0]    mem_time [RING_DEPTH];
  logic [PAYLOAD_W-1:0] mem_pay  [RING_DEPTH];

  logic                 op_r;
  logic [TIME_W-1:0]    time_r;
  logic [PAYLOAD_W-1:0] payload_r;

  logic [PTR_W-1:0]     oldest_r, wr_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [PTR_W-1:0]     oldest_succ;

  logic [TIME_W-1:0]    ta_rd_r, tb_rd_r;
  logic [PAYLOAD_W-1:0] pa_rd_r, pb_rd_r;

  logic                 found_r;
  logic [PAYLOAD_W-1:0] pa_r, pb_r;
  logic [ALPHA_W-1:0]   quot_r;
  logic [REM_W-1:0]     rem_r;
  logic [TIME_W-1:0]    den_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic [REM_W-1:0]     div_diff;
  logic                 div_ge;
  logic [REM_W-1:0]     rem_keep;
  logic [CNT_W+HELD_W-1:0] held_ext;

  assign oldest_succ = ring_next(oldest_r);

  always_ff @(posedge clk) begin
    if (cmd.do_write) begin
      mem_time[wr_r] <= time_r;
      mem_pay[wr_r]  <= payload_r;
    end
    if (cmd.rd_issue) begin
      ta_rd_r <= mem_time[oldest_r];
      tb_rd_r <= mem_time[oldest_succ];
      pa_rd_r <= mem_pay[oldest_r];
      pb_rd_r <= mem_pay[oldest_succ];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      wr_r     <= '0;
      cnt_r    <= '0;
    end else begin
      priority if (cmd.do_write) begin
        wr_r <= ring_next(wr_r);
        // full ring: the new word replaces the oldest one
        if (cnt_r == CNT_FULL) begin
          oldest_r <= oldest_succ;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else if (cmd.drop) begin
        oldest_r <= oldest_succ;
        cnt_r    <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_op;
      time_r    <= in_item_time;
      payload_r <= in_item_payload;
    end
  end

  // restoring divide: each step subtracts the divisor when the remainder is not below it
  assign div_diff = rem_r - {1'b0, den_r};
  assign div_ge   = (rem_r >= {1'b0, den_r});
  assign rem_keep = div_ge ? div_diff : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= DIV_STEPS;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.capture) begin
      found_r <= 1'b0;
      pa_r    <= '0;
      pb_r    <= '0;
      quot_r  <= '0;
    end else if (cmd.take_pair) begin
      found_r <= 1'b1;
      pa_r    <= pa_rd_r;
      pb_r    <= pb_rd_r;
      if (cmd.div_start) begin
        rem_r  <= {1'b0, time_r - ta_rd_r};
        den_r  <= tb_rd_r - ta_rd_r;
        quot_r <= '0;
      end
    end else if (cmd.div_step) begin
      rem_r  <= {rem_keep[REM_W-2:0], 1'b0};
      quot_r <= {quot_r[ALPHA_W-2:0], div_ge};
    end
  end

  assign held_ext = {{HELD_W{1'b0}}, cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_was_query       <= op_r;
      out_found           <= found_r;
      out_earlier_payload <= pa_r;
      out_later_payload   <= pb_r;
      out_alpha           <= quot_r;
      out_entries_held    <= held_ext[HELD_W-1:0];
    end
  end

  assign sts.few      = (cnt_r < CNT_TWO);
  assign sts.stale    = (tb_rd_r < time_r);
  assign sts.bracket  = (ta_rd_r <= time_r);
  assign sts.span     = (tb_rd_r > ta_rd_r);
  assign sts.div_last = (div_cnt_r == DIV_CNT_W'(1));

endmodule

// File: hw/rtl/timestamped_interpolation_ring.sv
// top level of the timestamped interpolation ring
// depends on tir_pkg, tir_ctrl and tir_dp
//
// Usage:
//   in_*  : one word per item. in_op = 0 stores (in_item_time, in_item_payload)
//           as the newest snapshot, overwriting the oldest when the ring is full.
//           in_op = 1 asks for the pair of snapshots around in_item_time.
//   out_* : one word per input word, in order. A found query returns both
//           payloads and alpha = (t - ta) / (tb - ta) in unsigned Q1.16.
// Sequencing:
//   one item at a time, next word taken the cycle after the result loads. A write
//   steps through write and emit; a query through read, check and emit (read and emit
//   with under two snapshots left), plus read and check per stale snapshot dropped,
//   as the memory read is registered, and a 1-bit-per-cycle divide when ta and tb differ.
// Reset:
//   rst_n low empties the ring at once; snapshot memory is not cleared.
// Back-pressure:
//   a finished word sits in the output register while out_ready is low; the
//   next input word is accepted meanwhile and holds in its last step until
//   the output register frees up.
module timestamped_interpolation_ring #(
  parameter int RING_DEPTH = tir_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [tir_pkg::TIME_W-1:0]    in_item_time,
  input  logic [tir_pkg::PAYLOAD_W-1:0] in_item_payload,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_was_query,
  output logic                          out_found,
  output logic [tir_pkg::PAYLOAD_W-1:0] out_earlier_payload,
  output logic [tir_pkg::PAYLOAD_W-1:0] out_later_payload,
  output logic [tir_pkg::ALPHA_W-1:0]   out_alpha,
  output logic [tir_pkg::HELD_W-1:0]    out_entries_held
);
  import tir_pkg::*;

  tir_cmd_t cmd;
  tir_sts_t sts;

  tir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tir_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_op               (in_op),
    .in_item_time        (in_item_time),
    .in_item_payload     (in_item_payload),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_was_query       (out_was_query),
    .out_found           (out_found),
    .out_earlier_payload (out_earlier_payload),
    .out_later_payload   (out_later_payload),
    .out_alpha           (out_alpha),
    .out_entries_held    (out_entries_held)
  );

endmodule

// File: hw/rtl/tir_checker.sv
// port-level checks for the timestamped interpolation ring
// depends on tir_pkg; attached to the top level by the bind below
module tir_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_was_query,
  input logic                          out_found,
  input logic [tir_pkg::PAYLOAD_W-1:0] out_earlier_payload,
  input logic [tir_pkg::ALPHA_W-1:0]   out_alpha
);
  import tir_pkg::*;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // only a query can find a pair
  a_found_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_was_query)
    else $error("found set on a write word");

  // no pair means no fraction and no payload
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_alpha == '0 && out_earlier_payload == '0)
    else $error("nonzero fields without a pair");

  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alpha <= ALPHA_ONE)
    else $error("alpha above one");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind timestamped_interpolation_ring tir_checker u_tir_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_was_query       (out_was_query),
  .out_found           (out_found),
  .out_earlier_payload (out_earlier_payload),
  .out_alpha           (out_alpha)
);

// File: verif/tir_interp_checker.sv
// checker for the timestamped interpolation ring: mirrors the snapshot ring,
// predicts one result word per accepted input word and compares in order
// depends on tir_pkg
module tir_interp_checker #(
  parameter int DEPTH = tir_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_op,
  input  logic [tir_pkg::TIME_W-1:0]    in_item_time,
  input  logic [tir_pkg::PAYLOAD_W-1:0] in_item_payload,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_was_query,
  input  logic                          out_found,
  input  logic [tir_pkg::PAYLOAD_W-1:0] out_earlier_payload,
  input  logic [tir_pkg::PAYLOAD_W-1:0] out_later_payload,
  input  logic [tir_pkg::ALPHA_W-1:0]   out_alpha,
  input  logic [tir_pkg::HELD_W-1:0]    out_entries_held,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import tir_pkg::*;

  typedef struct packed {
    logic                 was_query;
    logic                 found;
    logic [PAYLOAD_W-1:0] earlier;
    logic [PAYLOAD_W-1:0] later;
    logic [ALPHA_W-1:0]   alpha;
    logic [HELD_W-1:0]    held;
  } interp_result_t;

  logic [TIME_W-1:0]    snap_time    [DEPTH];
  logic [PAYLOAD_W-1:0] snap_payload [DEPTH];
  int                   oldest_idx;
  int                   write_idx;
  int                   held_cnt;
  interp_result_t       pending_results [$];

  function automatic int ring_next(int idx);
    return (idx + 1) % DEPTH;
  endfunction

  function automatic interp_result_t interpolate_step(logic op, logic [TIME_W-1:0] t,
                                                      logic [PAYLOAD_W-1:0] p);
    interp_result_t r;
    int             ia;
    int             ib;
    logic [63:0]    num;
    logic [63:0]    den;
    logic [63:0]    quo;
    bit             done;
    r = '0;
    r.was_query = op;
    if (op == OP_WRITE) begin
      if (held_cnt >= DEPTH) oldest_idx = ring_next(oldest_idx);
      else held_cnt++;
      snap_time[write_idx]    = t;
      snap_payload[write_idx] = p;
      write_idx = ring_next(write_idx);
    end else begin
      done = 1'b0;
      while (held_cnt >= 2 && !done) begin
        ia = oldest_idx;
        ib = ring_next(ia);
        if (snap_time[ib] < t) begin
          // stale: the successor is already older than the query
          oldest_idx = ib;
          held_cnt--;
        end else begin
          if (snap_time[ia] <= t) begin
            r.found   = 1'b1;
            r.earlier = snap_payload[ia];
            r.later   = snap_payload[ib];
            if (snap_time[ib] > snap_time[ia]) begin
              num = {t - snap_time[ia], 16'h0000};
              den = 64'(snap_time[ib] - snap_time[ia]);
              quo = num / den;
              r.alpha = quo[ALPHA_W-1:0];
            end
            oldest_idx = ib;
            held_cnt--;
          end
          done = 1'b1;
        end
      end
    end
    r.held = held_cnt[HELD_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    interp_result_t want;
    if (!rst_n) begin
      oldest_idx = 0;
      write_idx  = 0;
      held_cnt   = 0;
      mismatches = 0;
      pending_results.delete();
    end else begin
      // result side first: a word leaving now belongs to an earlier input word
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with nothing expected, actual found=%0b alpha=%0h",
                   $time, out_found, out_alpha);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("was_query", 64'(want.was_query), 64'(out_was_query));
          check_field("found", 64'(want.found), 64'(out_found));
          check_field("earlier_payload", want.earlier, out_earlier_payload);
          check_field("later_payload", want.later, out_later_payload);
          check_field("alpha", 64'(want.alpha), 64'(out_alpha));
          check_field("entries_held", 64'(want.held), 64'(out_entries_held));
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(interpolate_step(in_op, in_item_time, in_item_payload));
    end
    outstanding = pending_results.size();
  end

endmodule

// File: verif/tb.sv
// testbench top for the timestamped interpolation ring: drives snapshot and
// query words with random gaps and back-pressure, gives the verdict
// depends on tir_pkg, timestamped_interpolation_ring and tir_interp_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tir_pkg::*;

  localparam int RING_DEPTH = RING_DEPTH_DEF;
  localparam int N_WORDS    = 1500;
  localparam int CALM_TAIL  = 150;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_op           = OP_WRITE;
  logic [TIME_W-1:0]    in_item_time    = '0;
  logic [PAYLOAD_W-1:0] in_item_payload = '0;
  logic                 out_ready       = 1'b1;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_was_query;
  logic                 out_found;
  logic [PAYLOAD_W-1:0] out_earlier_payload;
  logic [PAYLOAD_W-1:0] out_later_payload;
  logic [ALPHA_W-1:0]   out_alpha;
  logic [HELD_W-1:0]    out_entries_held;
  int                   mismatches;
  int                   outstanding;

  int words_sent = 0;
  int idle_pct   = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  timestamped_interpolation_ring #(.RING_DEPTH(RING_DEPTH)) uut (.*);

  tir_interp_checker #(.DEPTH(RING_DEPTH)) chk (.*);

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [PAYLOAD_W-1:0] rand_payload();
    return {$urandom(), $urandom()};
  endfunction

  // random step below 2**k
  function automatic logic [TIME_W-1:0] rand_step(int k);
    return rand_time() & ((TIME_W'(1) << k) - TIME_W'(1));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(logic op, logic [TIME_W-1:0] t, logic [PAYLOAD_W-1:0] p);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(negedge clk);
    end
    in_op           <= op;
    in_item_time    <= t;
    in_item_payload <= p;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // snapshots at frame rate with a lagging render time
  task automatic frame_sequence();
    logic [TIME_W-1:0] wr_t;
    logic [TIME_W-1:0] rd_t;
    int                len;
    int                k;
    int                pick;
    len  = $urandom_range(40, 4);
    k    = $urandom_range(44, 0);
    wr_t = rand_time();
    rd_t = wr_t - rand_step(k);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 55) begin
        wr_t = wr_t + rand_step(k);
        send_word(OP_WRITE, wr_t, rand_payload());
      end else begin
        pick = $urandom_range(7);
        if (pick == 0) rd_t = wr_t;
        else if (pick > 1) rd_t = rd_t + rand_step(k);
        send_word(OP_QUERY, rd_t, rand_payload());
      end
    end
  endtask

  task automatic noise_sequence();
    int len;
    len = $urandom_range(12, 1);
    for (int i = 0; i < len; i++)
      send_word(logic'($urandom_range(1)), rand_time(), rand_payload());
  endtask

  // times going backwards, then a query a random step above the next time in the sequence
  task automatic backward_sequence();
    logic [TIME_W-1:0] t;
    int                len;
    t   = rand_time();
    len = $urandom_range(6, 2);
    for (int i = 0; i < len; i++) begin
      send_word(OP_WRITE, t, rand_payload());
      t = t - rand_step(20);
    end
    send_word(OP_QUERY, t + rand_step(22), rand_payload());
  endtask

  initial begin
    out_ready <= 1'b1;
    forever begin
      @(negedge clk);
      if (rst_n && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(19, 1)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    int kind;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty ring, single snapshot, equal times, query too old, alpha one
    send_word(OP_QUERY, '0, '1);
    send_word(OP_WRITE, 48'd100, '0);
    send_word(OP_QUERY, 48'd100, '0);
    send_word(OP_WRITE, 48'd100, '1);
    send_word(OP_QUERY, 48'd100, '0);
    send_word(OP_WRITE, 48'd300, 64'h5555_5555_5555_5555);
    send_word(OP_QUERY, 48'd50, '0);
    send_word(OP_QUERY, 48'd300, '0);
    send_word(OP_WRITE, '1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(OP_QUERY, 48'h8000_0000_0000, '1);
    // full ring overwrites the oldest, then a query that drops stale entries
    for (int i = 0; i < RING_DEPTH; i++)
      send_word(OP_WRITE, TIME_W'(1000 * (i + 1)), rand_payload());
    send_word(OP_QUERY, 48'd10500, '0);

    while (words_sent < N_WORDS) begin
      if (words_sent > N_WORDS - CALM_TAIL) idle_pct = 0;
      else idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(30, 5);
      kind = $urandom_range(9);
      if (kind < 7) frame_sequence();
      else if (kind < 9) noise_sequence();
      else backward_sequence();
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
